// ===== hw/rtl/can_transport_segmenter_core_macros.svh =====
// assertion macros shared by the segmenter rtl
`ifndef CAN_TRANSPORT_SEGMENTER_CORE_MACROS_SVH
`define CAN_TRANSPORT_SEGMENTER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cts_pkg.sv =====
// shared types and constants of the can transport segmenter
`default_nettype none
package cts_pkg;

	// sender phase codes
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SINGLE = 3'd1;
	localparam logic [2:0] PH_FIRST  = 3'd2;
	localparam logic [2:0] PH_WAIT   = 3'd3;
	localparam logic [2:0] PH_CONSEC = 3'd4;

	// frame layout constants
	localparam logic [11:0] SF_MAX  = 12'd7;
	localparam logic [2:0]  FF_DATA = 3'd6;
	localparam logic [2:0]  CF_DATA = 3'd7;
	localparam logic [3:0]  FF_PCI  = 4'h1;
	localparam logic [3:0]  CF_PCI  = 4'h2;
	localparam logic [3:0]  SEQ_START = 4'd1;

	localparam int unsigned MAX_RESULTS = 3;

	typedef struct packed {
		logic        func;
		logic [7:0]  payload_byte;
		logic        first_of_message;
		logic [11:0] message_length;
		logic [7:0]  block_size;
	} item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
		logic       status;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0]                      count;
		result_t [MAX_RESULTS-1:0]       res;
	} results_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cts_engine.sv =====
// segmentation state and per-item frame byte generation
`default_nettype none
`include "can_transport_segmenter_core_macros.svh"
module cts_engine (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cts_pkg::item_t   item,
	input  wire logic             commit,
	output cts_pkg::results_t     results
);

	logic [2:0]  phase_q, phase_d;
	logic [11:0] rem_q, rem_d;
	logic [2:0]  bif_q, bif_d;
	logic [3:0]  seq_q, seq_d;
	logic [7:0]  fsf_q, fsf_d;
	logic [7:0]  cbs_q, cbs_d;
	logic        sending;

	function automatic cts_pkg::result_t mk(input logic [7:0] b, input logic e, input logic st);
		cts_pkg::result_t r;
		r.frame_byte  = b;
		r.frame_end   = e;
		r.status      = st;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	always_comb begin
		logic [11:0] rem_dec;
		logic [2:0]  bif_inc;
		logic [7:0]  fsf_inc;
		logic        fr_end;
		logic [11:0] len;
		phase_d = phase_q;
		rem_d   = rem_q;
		bif_d   = bif_q;
		seq_d   = seq_q;
		fsf_d   = fsf_q;
		cbs_d   = cbs_q;
		results = '0;
		len     = item.message_length;
		rem_dec = rem_q - 12'd1;
		bif_inc = bif_q + 3'd1;
		fsf_inc = fsf_q + 8'd1;
		fr_end  = 1'b0;
		if (item.func) begin
			// flow control only matters while waiting
			if (phase_q == cts_pkg::PH_WAIT) begin
				cbs_d   = item.block_size;
				fsf_d   = 8'd0;
				bif_d   = 3'd0;
				phase_d = cts_pkg::PH_CONSEC;
			end
		end else if (item.first_of_message) begin
			bif_d = 3'd0;
			fsf_d = 8'd0;
			seq_d = cts_pkg::SEQ_START;
			if (len == 12'd0) begin
				phase_d = cts_pkg::PH_IDLE;
				rem_d   = 12'd0;
			end else begin
				rem_d = len - 12'd1;
				if (len <= cts_pkg::SF_MAX) begin
					results.res[0] = mk(len[7:0], 1'b0, 1'b0);
					results.res[1] = mk(item.payload_byte, (rem_d == 12'd0), 1'b0);
					results.count  = 2'd2;
					phase_d = (rem_d == 12'd0) ? cts_pkg::PH_IDLE : cts_pkg::PH_SINGLE;
				end else begin
					results.res[0] = mk({cts_pkg::FF_PCI, len[11:8]}, 1'b0, 1'b0);
					results.res[1] = mk(len[7:0], 1'b0, 1'b0);
					results.res[2] = mk(item.payload_byte, 1'b0, 1'b0);
					results.count  = 2'd3;
					bif_d   = 3'd1;
					phase_d = cts_pkg::PH_FIRST;
				end
			end
		end else begin
			case (phase_q)
				cts_pkg::PH_SINGLE: begin
					rem_d = rem_dec;
					results.res[0] = mk(item.payload_byte, (rem_dec == 12'd0), 1'b0);
					results.count  = 2'd1;
					if (rem_dec == 12'd0) begin
						phase_d = cts_pkg::PH_IDLE;
					end
				end
				cts_pkg::PH_FIRST: begin
					rem_d  = rem_dec;
					fr_end = (bif_inc >= cts_pkg::FF_DATA) || (rem_dec == 12'd0);
					results.res[0] = mk(item.payload_byte, fr_end, 1'b0);
					results.count  = 2'd1;
					if (fr_end) begin
						bif_d   = 3'd0;
						fsf_d   = 8'd0;
						phase_d = (rem_dec == 12'd0) ? cts_pkg::PH_IDLE : cts_pkg::PH_WAIT;
					end else begin
						bif_d = bif_inc;
					end
				end
				cts_pkg::PH_WAIT: begin
					// byte rejected, state untouched
					results.res[0] = mk(8'd0, 1'b0, 1'b1);
					results.count  = 2'd1;
				end
				cts_pkg::PH_CONSEC: begin
					rem_d  = rem_dec;
					fr_end = (bif_inc == cts_pkg::CF_DATA) || (rem_dec == 12'd0);
					if (bif_q == 3'd0) begin
						results.res[0] = mk({cts_pkg::CF_PCI, seq_q}, 1'b0, 1'b0);
						results.res[1] = mk(item.payload_byte, fr_end, 1'b0);
						results.count  = 2'd2;
						seq_d = seq_q + 4'd1;
					end else begin
						results.res[0] = mk(item.payload_byte, fr_end, 1'b0);
						results.count  = 2'd1;
					end
					if (fr_end) begin
						bif_d = 3'd0;
						fsf_d = fsf_inc;
						if (rem_dec == 12'd0) begin
							phase_d = cts_pkg::PH_IDLE;
						end else if ((cbs_q != 8'd0) && (fsf_inc == cbs_q)) begin
							fsf_d   = 8'd0;
							phase_d = cts_pkg::PH_WAIT;
						end
					end else begin
						bif_d = bif_inc;
					end
				end
				default: begin
					// idle or unused code: stray byte dropped
					phase_d = cts_pkg::PH_IDLE;
				end
			endcase
		end
		for (int i = 0; i < cts_pkg::MAX_RESULTS; i++) begin
			results.res[i].last_of_run = (2'(i) == (results.count - 2'd1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cts_pkg::PH_IDLE;
			rem_q   <= 12'd0;
			bif_q   <= 3'd0;
			seq_q   <= cts_pkg::SEQ_START;
			fsf_q   <= 8'd0;
			cbs_q   <= 8'd0;
		end else if (commit) begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			bif_q   <= bif_d;
			seq_q   <= seq_d;
			fsf_q   <= fsf_d;
			cbs_q   <= cbs_d;
		end
	end

	// phases that still owe message bytes
	assign sending = (phase_q == cts_pkg::PH_SINGLE) || (phase_q == cts_pkg::PH_FIRST) ||
		(phase_q == cts_pkg::PH_CONSEC);

	`CTS_ASSERT_NOW(a_wait_frame_closed, phase_q == cts_pkg::PH_WAIT, bif_q == 3'd0, "wait with open frame")
	`CTS_ASSERT_NOW(a_active_has_data, sending, rem_q != 12'd0, "sending phase with no bytes left")
	`CTS_ASSERT_NOW(a_cf_open, phase_q == cts_pkg::PH_CONSEC, bif_q < cts_pkg::CF_DATA, "frame overfull")

endmodule
`default_nettype wire

// ===== hw/rtl/cts_outbuf.sv =====
// three-entry result queue driving the master stream
`default_nettype none
`include "can_transport_segmenter_core_macros.svh"
module cts_outbuf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire cts_pkg::results_t  results,
	output logic                    free,
	input  wire logic               m_tready,
	output logic                    m_tvalid,
	output cts_pkg::result_t        head
);

	cts_pkg::result_t [cts_pkg::MAX_RESULTS-1:0] ent_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign m_tvalid = (cnt_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign head     = ent_q[0];
	// room for a new run once the last entry leaves
	assign free     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= results.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= results.res;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

	`CTS_ASSERT_NOW(a_load_when_free, load, (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop), "queue overwritten")
	`CTS_ASSERT_NOW(a_tail_is_last, cnt_q == 2'd1, ent_q[0].last_of_run, "final queued result not marked last")
	`CTS_ASSERT_NEXT(a_pop_count, pop && !load && (cnt_q > 2'd1), cnt_q == ($past(cnt_q) - 2'd1), "queue count slip")

endmodule
`default_nettype wire

// ===== hw/rtl/can_transport_segmenter_core.sv =====
// top level of the can transport (iso-tp) segmentation sender
// path: an accepted transaction passes the input register stage and the result queue
//   to the master side; its later bytes follow one per cycle while m_tready is high
// throughput: one transaction per cycle for items with at most one result while the master
//   side accepts; others wait until the single-entry-per-cycle result queue drains
// reset: arst_n asynchronous active low; idle phase, sequence 1, empty input and output stages
`default_nettype none
module can_transport_segmenter_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side: incoming payload bytes and flow control
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // payload_byte[7:0], first_of_message[8],
	                                   // message_length[20:9], block_size[28:21], zero pad
	input  wire logic        s_tuser,  // func: 0 payload byte, 1 flow control frame
	// master side: outgoing frame bytes
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // frame_byte[7:0], last_of_run[8], zero pad
	output logic             m_tuser,  // status: 1 byte rejected while awaiting flow control
	output logic             m_tlast   // frame_end: last byte of a can frame
);

	// input register stage
	cts_pkg::item_t    item_s1;
	logic              valid_s1;
	cts_pkg::results_t results;
	cts_pkg::result_t  head;
	logic              free;
	logic              commit;
	logic              load;

	// an item with no frame bytes retires without the queue; others need it free
	assign commit   = valid_s1 && ((results.count == 2'd0) || free);
	assign load     = commit && (results.count != 2'd0);
	assign s_tready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func             <= s_tuser;
			item_s1.payload_byte     <= s_tdata[7:0];
			item_s1.first_of_message <= s_tdata[8];
			item_s1.message_length   <= s_tdata[20:9];
			item_s1.block_size       <= s_tdata[28:21];
		end
	end

	// segmentation state and frame byte generation
	cts_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.commit  (commit),
		.results (results)
	);

	// result queue, one frame byte per master-side transfer, up to three per transaction
	cts_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.results  (results),
		.free     (free),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.head     (head)
	);

	assign m_tdata = {7'd0, head.last_of_run, head.frame_byte};
	assign m_tuser = head.status;
	assign m_tlast = head.frame_end;

endmodule
`default_nettype wire
